>>> rtl/mssc_pkg.sv
// Shared types and result codes for the minimum square sum count block.
package mssc_pkg;

	localparam int COUNT_BITS = 3;

	localparam logic [COUNT_BITS-1:0] COUNT_ZERO  = 3'd0;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE   = 3'd1;
	localparam logic [COUNT_BITS-1:0] COUNT_TWO   = 3'd2;
	localparam logic [COUNT_BITS-1:0] COUNT_THREE = 3'd3;
	localparam logic [COUNT_BITS-1:0] COUNT_FOUR  = 3'd4;

	typedef struct packed {
		logic load;
		logic sqrt_step;
		logic pair_init;
		logic pair_step;
		logic strip_step;
	} cmd_t;

	typedef struct packed {
		logic zero;
		logic sqrt_done;
		logic is_sq;
		logic pair_over;
		logic pair_found;
		logic strip_done;
		logic form7;
	} sts_t;

endpackage

>>> rtl/min_square_sum_count_top.sv
// Top level of the minimum square sum count block.
//
//  channel  signals                        beat
//  input    in_valid / in_stall / value    one unsigned integer
//  output   out_valid / out_stall          square_count, 0 to 4
//
// One beat at a time: a load, a digit-serial square root and a branch pick, then the
// two-pointer pair search when the value is neither zero nor a square, then the
// factor-of-four strip when no pair is found, and last the hand-over of the result.
// Reset clears the controller and the result valid flag at once.
// A new beat is taken while the previous result waits under out_stall.
module min_square_sum_count_top #(
	parameter int VALUE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [VALUE_BITS-1:0]           value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mssc_pkg::COUNT_BITS-1:0] square_count
);

	mssc_pkg::cmd_t cmd;
	mssc_pkg::sts_t sts;

	mssc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.square_count (square_count),
		.cmd          (cmd),
		.sts          (sts)
	);

	mssc_dpath #(
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk   (clk),
		.value (value),
		.cmd   (cmd),
		.sts   (sts)
	);

endmodule

>>> rtl/mssc_dpath.sv
// Datapath: digit-serial square root, two-pointer pair search and factor-of-four strip.
module mssc_dpath #(
	parameter int VALUE_BITS = 16
) (
	input  logic                  clk,
	input  logic [VALUE_BITS-1:0] value,
	input  mssc_pkg::cmd_t        cmd,
	output mssc_pkg::sts_t        sts
);

	localparam int HALF = (VALUE_BITS + 1) / 2;
	localparam int RW   = 2 * HALF;
	localparam int SW   = RW + 1;
	localparam int AW   = HALF + 1;

	logic [RW-1:0]         n_q;
	logic [RW-1:0]         rem_q;
	logic [RW-1:0]         root_q;
	logic [RW-1:0]         bit_q;
	logic [AW-1:0]         a_q;
	logic [AW-1:0]         b_q;
	logic [SW-1:0]         a2_q;
	logic [SW-1:0]         b2_q;
	logic [VALUE_BITS-1:0] m_q;

	logic [RW:0]   trial;
	logic          take;
	logic [SW:0]   sum;
	logic [SW:0]   n_ext;
	logic          over;

	assign trial = {1'b0, root_q} + {1'b0, bit_q};
	assign take  = {1'b0, rem_q} >= trial;
	assign sum   = {1'b0, a2_q} + {1'b0, b2_q};
	assign n_ext = {2'b00, n_q};
	assign over  = a_q > b_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= RW'(value);
			rem_q  <= RW'(value);
			root_q <= '0;
			bit_q  <= RW'(1) << (RW - 2);
			m_q    <= value;
		end else begin
			if (cmd.sqrt_step) begin
				if (take) begin
					rem_q  <= rem_q - trial[RW-1:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			if (cmd.strip_step) begin
				m_q <= m_q >> 2;
			end
		end
		if (cmd.pair_init) begin
			a_q  <= AW'(1);
			a2_q <= SW'(1);
			b_q  <= {1'b0, root_q[HALF-1:0]};
			b2_q <= {1'b0, n_q - rem_q};
		end else if (cmd.pair_step) begin
			if (sum < n_ext) begin
				a2_q <= a2_q + SW'({a_q, 1'b1});
				a_q  <= a_q + AW'(1);
			end else begin
				b2_q <= b2_q - SW'({b_q, 1'b0}) + SW'(1);
				b_q  <= b_q - AW'(1);
			end
		end
	end

	always_comb begin
		sts.zero       = n_q == '0;
		sts.sqrt_done  = bit_q == '0;
		sts.is_sq      = rem_q == '0;
		sts.pair_over  = over;
		sts.pair_found = !over && (sum == n_ext);
		sts.strip_done = m_q[1:0] != 2'b00;
		sts.form7      = m_q[2:0] == 3'b111;
	end

endmodule

>>> rtl/mssc_ctrl.sv
// Controller: sequences root, pair search and strip, and holds the result beat.
module mssc_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mssc_pkg::COUNT_BITS-1:0]     square_count,
	output mssc_pkg::cmd_t                      cmd,
	input  mssc_pkg::sts_t                      sts
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SQRT  = 3'd1;
	localparam logic [2:0] ST_PAIR  = 3'd2;
	localparam logic [2:0] ST_STRIP = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]                            state_q;
	logic [2:0]                            state_d;
	logic [mssc_pkg::COUNT_BITS-1:0]       result_q;
	logic [mssc_pkg::COUNT_BITS-1:0]       result_d;
	logic                                  out_valid_q;
	logic [mssc_pkg::COUNT_BITS-1:0]       square_count_q;
	logic                                  out_free;
	logic                                  emit;

	assign in_stall     = state_q != ST_IDLE;
	assign out_valid    = out_valid_q;
	assign square_count = square_count_q;
	assign out_free     = !out_valid_q || !out_stall;
	assign emit         = (state_q == ST_FIN) && out_free;

	always_comb begin
		state_d        = state_q;
		result_d       = result_q;
		cmd.load       = 1'b0;
		cmd.sqrt_step  = 1'b0;
		cmd.pair_init  = 1'b0;
		cmd.pair_step  = 1'b0;
		cmd.strip_step = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (!sts.sqrt_done) begin
					cmd.sqrt_step = 1'b1;
				end else if (sts.zero) begin
					result_d = mssc_pkg::COUNT_ZERO;
					state_d  = ST_FIN;
				end else if (sts.is_sq) begin
					result_d = mssc_pkg::COUNT_ONE;
					state_d  = ST_FIN;
				end else begin
					cmd.pair_init = 1'b1;
					state_d       = ST_PAIR;
				end
			end
			ST_PAIR: begin
				if (sts.pair_found) begin
					result_d = mssc_pkg::COUNT_TWO;
					state_d  = ST_FIN;
				end else if (sts.pair_over) begin
					state_d = ST_STRIP;
				end else begin
					cmd.pair_step = 1'b1;
				end
			end
			ST_STRIP: begin
				if (sts.strip_done) begin
					result_d = sts.form7 ? mssc_pkg::COUNT_FOUR : mssc_pkg::COUNT_THREE;
					state_d  = ST_FIN;
				end else begin
					cmd.strip_step = 1'b1;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
		if (emit) begin
			square_count_q <= result_q;
		end
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.sqrt_step, cmd.pair_init, cmd.pair_step, cmd.strip_step}))
		else $error("more than one datapath command in a cycle");

	a_load_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_SQRT)
		else $error("accepted beat did not start the root");

	a_found_fin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PAIR && sts.pair_found
		|=> state_q == ST_FIN && result_q == mssc_pkg::COUNT_TWO)
		else $error("pair found but no two-square result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> square_count_q <= mssc_pkg::COUNT_FOUR)
		else $error("result beat out of range");

endmodule

>>> dv/mssc_checker.sv
// Checker for the minimum square sum count block: predicts each count and compares results.
`timescale 1ns / 100ps

module mssc_checker #(
	parameter int VALUE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [VALUE_BITS-1:0]           value,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [mssc_pkg::COUNT_BITS-1:0] square_count,
	output int                              taken_count,
	output int                              waiting_count,
	output int                              error_count
);

	typedef logic [mssc_pkg::COUNT_BITS-1:0] count_t;

	typedef struct {
		logic [VALUE_BITS-1:0] operand;
		count_t                count;
	} count_entry_t;

	count_entry_t expected_counts_q[$];

	function automatic int unsigned floor_root(int unsigned x);
		longint unsigned r;
		longint unsigned cand;
		int b;
		r = 0;
		for (b = 15; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			if (cand * cand <= x) begin
				r = cand;
			end
		end
		return r[31:0];
	endfunction

	function automatic count_t least_square_count(logic [VALUE_BITS-1:0] v);
		int unsigned n;
		int unsigned root;
		int unsigned lim;
		int unsigned a;
		int unsigned rest;
		int unsigned m;
		n = 32'(v);
		if (n == 0) begin
			return mssc_pkg::COUNT_ZERO;
		end
		root = floor_root(n);
		if (root * root == n) begin
			return mssc_pkg::COUNT_ONE;
		end
		lim = floor_root(n / 2);
		for (a = 1; a <= lim; a++) begin
			rest = n - a * a;
			root = floor_root(rest);
			if (rest != 0 && root * root == rest) begin
				return mssc_pkg::COUNT_TWO;
			end
		end
		m = n;
		while ((m & 32'd3) == 0) begin
			m = m >> 2;
		end
		if ((m & 32'd7) == 32'd7) begin
			return mssc_pkg::COUNT_FOUR;
		end
		return mssc_pkg::COUNT_THREE;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	always @(posedge clk) begin
		count_entry_t want;
		count_entry_t got_in;
		if (!arst_n) begin
			taken_count   = 0;
			waiting_count = 0;
			error_count   = 0;
			expected_counts_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_counts_q.size() == 0) begin
					report_mismatch($sformatf("square_count %0d with no beat waiting",
						square_count));
				end else begin
					want = expected_counts_q.pop_front();
					if (square_count !== want.count) begin
						report_mismatch($sformatf("value %0d: square_count %0d, predicted %0d",
							want.operand, square_count, want.count));
					end
				end
			end
			if (in_valid && !in_stall) begin
				got_in.operand = value;
				got_in.count   = least_square_count(value);
				expected_counts_q = {expected_counts_q, got_in};
				taken_count++;
			end
			waiting_count = expected_counts_q.size();
		end
	end

endmodule

>>> dv/tb.sv
// Testbench top for the minimum square sum count block: reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb;

	localparam int VALUE_BITS   = 16;
	localparam int RANDOM_ITEMS = 1130;
	localparam int DRAIN_CYCLES = 400;
	localparam int CYCLE_LIMIT  = 2_500_000;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	logic [VALUE_BITS-1:0]           value;
	logic                            out_valid;
	logic                            out_stall;
	logic [mssc_pkg::COUNT_BITS-1:0] square_count;

	int taken_count;
	int waiting_count;
	int error_count;
	int sent_count;
	int cycle_count = 0;
	bit calm_input;

	logic [VALUE_BITS-1:0] directed_values [23] = '{
		16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8, 16'd12, 16'd15,
		16'd25, 16'd28, 16'd50, 16'd112, 16'd1024, 16'd32768, 16'd49152, 16'd65025,
		16'd65532, 16'd65534, 16'd65535, 16'h5555, 16'hAAAA
	};

	min_square_sum_count_top #(
		.VALUE_BITS(VALUE_BITS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.square_count(square_count)
	);

	mssc_checker #(
		.VALUE_BITS(VALUE_BITS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.square_count (square_count),
		.taken_count  (taken_count),
		.waiting_count(waiting_count),
		.error_count  (error_count)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(20, 80);
	endfunction

	task automatic send_value(logic [VALUE_BITS-1:0] v);
		int gap;
		in_valid <= 1'b1;
		value    <= v;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sent_count++;
		gap = calm_input ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int stall_len;
		out_stall = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 7) == 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(200, 800)) @(posedge clk);
			end else begin
				stall_len = idle_len();
				if (stall_len > 0) begin
					out_stall <= 1'b1;
					repeat (stall_len) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int i;
		int kind;
		int a;
		int b;
		int k;
		int base;
		int m;
		logic [VALUE_BITS-1:0] v;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		value      = '0;
		calm_input = 1'b0;
		sent_count = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_values[j]) begin
			send_value(directed_values[j]);
		end

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			calm_input = (i >= 500 && i < 620);
			kind = $urandom_range(0, 9);
			case (kind)
				3: begin
					v = VALUE_BITS'($urandom_range(1, 400));
				end
				4: begin
					a = $urandom_range(1, 255);
					v = VALUE_BITS'(a * a);
				end
				5, 6: begin
					a = $urandom_range(1, 180);
					b = $urandom_range(1, 180);
					v = VALUE_BITS'(a * a + b * b);
				end
				7: begin
					k    = $urandom_range(0, 6);
					base = 65535 >> (2 * k);
					m    = $urandom_range(0, (base - 7) / 8);
					v    = VALUE_BITS'((8 * m + 7) << (2 * k));
				end
				8: begin
					k = $urandom_range(1, 7);
					v = VALUE_BITS'($urandom_range(1, 65535 >> (2 * k)) << (2 * k));
				end
				9: begin
					v = VALUE_BITS'($urandom_range(65000, 65535));
				end
				default: begin
					v = VALUE_BITS'($urandom_range(1, 65535));
				end
			endcase
			send_value(v);
		end
		in_valid <= 1'b0;

		wait (taken_count == sent_count && waiting_count == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/mssc_pkg.sv
rtl/mssc_dpath.sv
rtl/mssc_ctrl.sv
rtl/min_square_sum_count_top.sv
dv/mssc_checker.sv
dv/tb.sv
